### rtl/bve_pkg.sv
// Shared types, codes and arithmetic helpers for the Bezier volume evaluator.
package bve_pkg;

   // Counter and index fields carried between controller and lanes
   localparam int IDX_MAX_W = 4;

   localparam logic       OP_WRITE = 1'b0;
   localparam logic       OP_EVAL  = 1'b1;

   localparam logic [1:0] CSR_DEGREE_I = 2'd0;
   localparam logic [1:0] CSR_DEGREE_J = 2'd1;
   localparam logic [1:0] CSR_DEGREE_K = 2'd2;

   localparam logic [2:0]  DEGREE_RESET = 3'd3;
   localparam logic [16:0] ONE_Q16      = 17'd65536;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOADK,
      ST_SETUP,
      ST_RED,
      ST_DRAIN,
      ST_STORE,
      ST_OUTPUT
   } state_type;

   typedef enum logic [1:0] {
      LVL_K,
      LVL_J,
      LVL_I
   } level_type;

   typedef struct packed {
      logic                 ld_en;
      logic [IDX_MAX_W-1:0] ld_idx;
      logic                 copy_col;
      logic                 copy_pl;
      logic                 mul_en;
      logic [16:0]          t;
      logic                 add_en;
      logic [IDX_MAX_W-1:0] add_idx;
      logic                 add_last;
      logic                 col_wr;
      logic                 pl_wr;
      logic [IDX_MAX_W-1:0] st_idx;
      logic                 out_load;
   } lane_cmd_type;

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      logic signed [35:0] hi;
      logic signed [35:0] lo;
      hi = 36'sd2147483647;
      lo = -36'sd2147483648;
      if (v > hi) begin
         sat32 = 32'sh7fffffff;
      end else if (v < lo) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

   function automatic logic [16:0] clamp_param(input logic [16:0] p);
      clamp_param = (p > ONE_Q16) ? ONE_Q16 : p;
   endfunction

endpackage

### rtl/bve_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bve_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### rtl/bve_lane.sv
// One coordinate lane: reduction buffers, interpolation multiplier and result register.
module bve_lane #(
   parameter int SIDE  = 8,
   parameter int IDX_W = 3
) (
   input  logic                clock,
   input  bve_pkg::lane_cmd_type cmd,
   input  logic [31:0]         ram_rdata,
   output logic signed [31:0]  disp
);
   import bve_pkg::*;

   logic signed [31:0] cbuf_ff [SIDE];
   logic signed [31:0] cbuf_in [SIDE];
   logic signed [31:0] nbuf_ff [SIDE];
   logic signed [31:0] nbuf_in [SIDE];
   logic signed [31:0] col_ff  [SIDE];
   logic signed [31:0] col_in  [SIDE];
   logic signed [31:0] pl_ff   [SIDE];
   logic signed [31:0] pl_in   [SIDE];
   logic signed [31:0] a_ff;
   logic signed [50:0] prod_ff;
   logic signed [50:0] prod_in;
   logic signed [31:0] disp_ff;
   logic signed [31:0] disp_in;

   logic signed [32:0] diff;
   logic signed [17:0] t_s;
   logic signed [50:0] rnd;
   logic signed [35:0] sum;
   logic signed [31:0] res;
   logic [IDX_W-1:0]   li;
   logic [IDX_W-1:0]   ai;
   logic [IDX_W-1:0]   si;

   assign li = cmd.ld_idx[IDX_W-1:0];
   assign ai = cmd.add_idx[IDX_W-1:0];
   assign si = cmd.st_idx[IDX_W-1:0];

   // Multiply the operand difference by the parameter
   assign diff    = {cbuf_ff[1][31], cbuf_ff[1]} - {cbuf_ff[0][31], cbuf_ff[0]};
   assign t_s     = $signed({1'b0, cmd.t});
   assign prod_in = diff * t_s;

   // Round half up for both signs, then add back the base
   assign rnd = (prod_ff + 51'sd32768) >>> 16;
   assign sum = 36'(a_ff) + 36'($signed(rnd[34:0]));
   assign res = sat32(sum);

   always_comb begin
      cbuf_in = cbuf_ff;
      nbuf_in = nbuf_ff;
      col_in  = col_ff;
      pl_in   = pl_ff;
      disp_in = disp_ff;
      priority if (cmd.ld_en) begin
         cbuf_in[li] = ram_rdata;
      end else if (cmd.copy_col) begin
         cbuf_in = col_ff;
      end else if (cmd.copy_pl) begin
         cbuf_in = pl_ff;
      end else if (cmd.mul_en) begin
         for (int k = 0; k < SIDE - 1; k++) begin
            cbuf_in[k] = cbuf_ff[k+1];
         end
      end else if (cmd.add_en && cmd.add_last) begin
         cbuf_in     = nbuf_ff;
         cbuf_in[ai] = res;
      end
      if (cmd.add_en) begin
         nbuf_in[ai] = res;
      end
      if (cmd.col_wr) begin
         col_in[si] = cbuf_ff[0];
      end
      if (cmd.pl_wr) begin
         pl_in[si] = cbuf_ff[0];
      end
      if (cmd.out_load) begin
         disp_in = cbuf_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      cbuf_ff <= cbuf_in;
      nbuf_ff <= nbuf_in;
      col_ff  <= col_in;
      pl_ff   <= pl_in;
      a_ff    <= cbuf_ff[0];
      prod_ff <= prod_in;
      disp_ff <= disp_in;
   end

   assign disp = disp_ff;
endmodule

### rtl/bve_ctrl.sv
// Controller: handshakes, degree registers and the reduction sequencer.
module bve_ctrl #(
   parameter int MAX_DEGREE = 7,
   parameter int IDX_W      = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_op,
   input  logic [2:0]             req_index_i,
   input  logic [2:0]             req_index_j,
   input  logic [2:0]             req_index_k,
   input  logic [16:0]            req_param_u,
   input  logic [16:0]            req_param_v,
   input  logic [16:0]            req_param_w,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [2:0]             csr_data,
   output logic                   ram_we,
   output logic [3*IDX_W-1:0]     ram_waddr,
   output logic [3*IDX_W-1:0]     ram_raddr,
   output bve_pkg::lane_cmd_type  cmd
);
   import bve_pkg::*;

   state_type        state_ff, state_in;
   level_type        lvl_ff, lvl_in;
   logic [IDX_W-1:0] ci_ff, ci_in, cj_ff, cj_in, ck_ff, ck_in;
   logic [IDX_W-1:0] m_ff, m_in, len_ff, len_in;
   logic [2:0]       deg_i_ff, deg_i_in, deg_j_ff, deg_j_in, deg_k_ff, deg_k_in;
   logic [16:0]      pu_ff, pu_in, pv_ff, pv_in, pw_ff, pw_in;
   logic             ld_en_ff, ld_en_in;
   logic [IDX_W-1:0] ld_idx_ff, ld_idx_in;
   logic             add_en_ff, add_en_in, add_last_ff, add_last_in;
   logic [IDX_W-1:0] add_idx_ff, add_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [IDX_W-1:0] ni, nj, nk, nlvl;
   logic             idx_ok;

   assign ni = (int'(deg_i_ff) > MAX_DEGREE) ? IDX_W'(MAX_DEGREE) : IDX_W'(deg_i_ff);
   assign nj = (int'(deg_j_ff) > MAX_DEGREE) ? IDX_W'(MAX_DEGREE) : IDX_W'(deg_j_ff);
   assign nk = (int'(deg_k_ff) > MAX_DEGREE) ? IDX_W'(MAX_DEGREE) : IDX_W'(deg_k_ff);

   assign idx_ok = (int'(req_index_i) <= MAX_DEGREE) && (int'(req_index_j) <= MAX_DEGREE)
                   && (int'(req_index_k) <= MAX_DEGREE);

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign ram_waddr = {IDX_W'(req_index_i), IDX_W'(req_index_j), IDX_W'(req_index_k)};
   assign ram_raddr = {ci_ff, cj_ff, ck_ff};

   always_comb begin
      deg_i_in = deg_i_ff;
      deg_j_in = deg_j_ff;
      deg_k_in = deg_k_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DEGREE_I: deg_i_in = csr_data;
            CSR_DEGREE_J: deg_j_in = csr_data;
            CSR_DEGREE_K: deg_k_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (lvl_ff)
         LVL_K:   nlvl = nk;
         LVL_J:   nlvl = nj;
         default: nlvl = ni;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      lvl_in      = lvl_ff;
      ci_in       = ci_ff;
      cj_in       = cj_ff;
      ck_in       = ck_ff;
      m_in        = m_ff;
      len_in      = len_ff;
      pu_in       = pu_ff;
      pv_in       = pv_ff;
      pw_in       = pw_ff;
      ld_en_in    = 1'b0;
      ld_idx_in   = ck_ff;
      add_en_in   = 1'b0;
      add_idx_in  = m_ff;
      add_last_in = 1'b0;
      req_ready   = 1'b0;
      ram_we      = 1'b0;

      cmd          = '0;
      cmd.ld_en    = ld_en_ff;
      cmd.ld_idx   = IDX_MAX_W'(ld_idx_ff);
      cmd.add_en   = add_en_ff;
      cmd.add_idx  = IDX_MAX_W'(add_idx_ff);
      cmd.add_last = add_last_ff;
      unique case (lvl_ff)
         LVL_K:   cmd.t = pw_ff;
         LVL_J:   cmd.t = pv_ff;
         default: cmd.t = pu_ff;
      endcase

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_op == OP_WRITE) begin
                  ram_we = idx_ok;
               end else begin
                  pu_in    = clamp_param(req_param_u);
                  pv_in    = clamp_param(req_param_v);
                  pw_in    = clamp_param(req_param_w);
                  ci_in    = '0;
                  cj_in    = '0;
                  ck_in    = '0;
                  lvl_in   = LVL_K;
                  state_in = ST_LOADK;
               end
            end
         end
         ST_LOADK: begin
            ld_en_in = 1'b1;
            if (ck_ff == nk) begin
               state_in = ST_SETUP;
            end else begin
               ck_in = ck_ff + 1'b1;
            end
         end
         ST_SETUP: begin
            cmd.copy_col = (lvl_ff == LVL_J);
            cmd.copy_pl  = (lvl_ff == LVL_I);
            len_in       = nlvl;
            m_in         = '0;
            state_in     = (nlvl == '0) ? ST_STORE : ST_RED;
         end
         ST_RED: begin
            cmd.mul_en  = 1'b1;
            add_en_in   = 1'b1;
            add_last_in = (m_ff == len_ff - 1'b1);
            if (m_ff == len_ff - 1'b1) begin
               state_in = ST_DRAIN;
            end else begin
               m_in = m_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            // the round's last result merges into the working buffer now
            if (len_ff == IDX_W'(1)) begin
               state_in = ST_STORE;
            end else begin
               len_in   = len_ff - 1'b1;
               m_in     = '0;
               state_in = ST_RED;
            end
         end
         ST_STORE: begin
            unique case (lvl_ff)
               LVL_K: begin
                  cmd.col_wr = 1'b1;
                  cmd.st_idx = IDX_MAX_W'(cj_ff);
                  if (cj_ff == nj) begin
                     lvl_in   = LVL_J;
                     state_in = ST_SETUP;
                  end else begin
                     cj_in    = cj_ff + 1'b1;
                     ck_in    = '0;
                     state_in = ST_LOADK;
                  end
               end
               LVL_J: begin
                  cmd.pl_wr  = 1'b1;
                  cmd.st_idx = IDX_MAX_W'(ci_ff);
                  if (ci_ff == ni) begin
                     lvl_in   = LVL_I;
                     state_in = ST_SETUP;
                  end else begin
                     ci_in    = ci_ff + 1'b1;
                     cj_in    = '0;
                     ck_in    = '0;
                     lvl_in   = LVL_K;
                     state_in = ST_LOADK;
                  end
               end
               default: begin
                  state_in = ST_OUTPUT;
               end
            endcase
         end
         ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lvl_ff       <= LVL_K;
         deg_i_ff     <= DEGREE_RESET;
         deg_j_ff     <= DEGREE_RESET;
         deg_k_ff     <= DEGREE_RESET;
         ld_en_ff     <= 1'b0;
         add_en_ff    <= 1'b0;
         add_last_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lvl_ff       <= lvl_in;
         deg_i_ff     <= deg_i_in;
         deg_j_ff     <= deg_j_in;
         deg_k_ff     <= deg_k_in;
         ld_en_ff     <= ld_en_in;
         add_en_ff    <= add_en_in;
         add_last_ff  <= add_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ci_ff      <= ci_in;
      cj_ff      <= cj_in;
      ck_ff      <= ck_in;
      m_ff       <= m_in;
      len_ff     <= len_in;
      pu_ff      <= pu_in;
      pv_ff      <= pv_in;
      pw_ff      <= pw_in;
      ld_idx_ff  <= ld_idx_in;
      add_idx_ff <= add_idx_in;
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && !rsp_ready))
      else $error("pending result overwritten");

   a_step_in_round: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_en |-> (m_ff < len_ff))
      else $error("interpolation step beyond round length");

   a_merge_alone: assert property (@(posedge clock) disable iff (reset)
      (cmd.add_en && cmd.add_last) |-> !cmd.mul_en && $past(state_ff == ST_RED))
      else $error("round merge collides with a shift");

   a_read_in_degree: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOADK) |-> (ck_ff <= nk) && (cj_ff <= nj) && (ci_ff <= ni))
      else $error("lattice read outside active degree");
endmodule

### rtl/bezier_volume_evaluator_unit.sv
// Top level: trivariate Bezier volume evaluator with lattice memories and three lanes.
// A write item goes straight into the lattice memories; the next item is taken in the following cycle.
// An evaluate item uses the degrees clamped to MAX_DEGREE and holds off new items until its
// result is loaded; its run time is set by the one shared interpolation multiplier per lane
// and the single lattice read port.
// Reset idles the controller, clears rsp_valid and sets all three degrees to 3; the lattice is undefined.
module bezier_volume_evaluator_unit #(
   parameter int MAX_DEGREE = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic [2:0]         req_index_i,
   input  logic [2:0]         req_index_j,
   input  logic [2:0]         req_index_k,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   input  logic [16:0]        req_param_u,
   input  logic [16:0]        req_param_v,
   input  logic [16:0]        req_param_w,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_disp_x,
   output logic signed [31:0] rsp_disp_y,
   output logic signed [31:0] rsp_disp_z,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [2:0]         csr_data
);
   import bve_pkg::*;

   localparam int SIDE  = MAX_DEGREE + 1;
   localparam int IDX_W = $clog2(SIDE);
   localparam int AW    = 3 * IDX_W;
   localparam int DEPTH = 2 ** AW;

   lane_cmd_type    cmd;
   logic            ram_we;
   logic [AW-1:0]   ram_waddr;
   logic [AW-1:0]   ram_raddr;
   logic [31:0]     rdata_x, rdata_y, rdata_z;

   // Sequencer: walks the lattice row by row and drives the lanes
   bve_ctrl #(.MAX_DEGREE(MAX_DEGREE), .IDX_W(IDX_W)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_op     (req_op),
      .req_index_i(req_index_i),
      .req_index_j(req_index_j),
      .req_index_k(req_index_k),
      .req_param_u(req_param_u),
      .req_param_v(req_param_v),
      .req_param_w(req_param_w),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_raddr  (ram_raddr),
      .cmd        (cmd)
   );

   // Control point stores, one per coordinate
   bve_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_x (
      .clock(clock), .we(ram_we), .waddr(ram_waddr), .wdata(req_point_x),
      .raddr(ram_raddr), .rdata(rdata_x)
   );
   bve_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_y (
      .clock(clock), .we(ram_we), .waddr(ram_waddr), .wdata(req_point_y),
      .raddr(ram_raddr), .rdata(rdata_y)
   );
   bve_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_z (
      .clock(clock), .we(ram_we), .waddr(ram_waddr), .wdata(req_point_z),
      .raddr(ram_raddr), .rdata(rdata_z)
   );

   // Coordinate lanes run in lockstep under the same commands
   bve_lane #(.SIDE(SIDE), .IDX_W(IDX_W)) u_lane_x (
      .clock(clock), .cmd(cmd), .ram_rdata(rdata_x), .disp(rsp_disp_x)
   );
   bve_lane #(.SIDE(SIDE), .IDX_W(IDX_W)) u_lane_y (
      .clock(clock), .cmd(cmd), .ram_rdata(rdata_y), .disp(rsp_disp_y)
   );
   bve_lane #(.SIDE(SIDE), .IDX_W(IDX_W)) u_lane_z (
      .clock(clock), .cmd(cmd), .ram_rdata(rdata_z), .disp(rsp_disp_z)
   );
endmodule
